FILE: sv/icds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icds_pkg
// Shared types, constants and the divider table for the clock divider search.
// ----------------------------------------------------------------------------
package icds_pkg;

	localparam int unsigned ENTRY_COUNT = 50;
	localparam int unsigned SHIFT_COUNT = 3;
	localparam int unsigned IDX_W       = 6;
	localparam int unsigned DEN_W       = 14;
	localparam int unsigned DIVR_W      = 12;
	localparam logic [DEN_W-1:0] MIN_DIVIDER = 14'd20;
	localparam logic [IDX_W-1:0] LAST_IDX    = 6'(ENTRY_COUNT - 1);
	localparam logic [1:0]       LAST_SHIFT  = 2'(SHIFT_COUNT - 1);

	typedef struct packed {
		logic [5:0]        code;
		logic [DIVR_W-1:0] divider;
	} div_entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // latch new word
		logic step;     // one quotient bit
		logic start;    // start division for current candidate
		logic reject;   // rate too high
		logic eval;     // compare candidate against best
		logic next;     // advance to next candidate
	} icds_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_last;
		logic reject;
		logic exact;
		logic last_cand;
	} icds_status_t;

	function automatic div_entry_t div_table(input logic [IDX_W-1:0] idx);
		div_entry_t e;
		unique case (idx)
			6'd0:  e = '{6'h00, 12'd20};
			6'd1:  e = '{6'h01, 12'd22};
			6'd2:  e = '{6'h02, 12'd24};
			6'd3:  e = '{6'h03, 12'd26};
			6'd4:  e = '{6'h04, 12'd28};
			6'd5:  e = '{6'h05, 12'd30};
			6'd6:  e = '{6'h09, 12'd32};
			6'd7:  e = '{6'h06, 12'd34};
			6'd8:  e = '{6'h0a, 12'd36};
			6'd9:  e = '{6'h07, 12'd40};
			6'd10: e = '{6'h0c, 12'd44};
			6'd11: e = '{6'h0d, 12'd48};
			6'd12: e = '{6'h0e, 12'd56};
			6'd13: e = '{6'h12, 12'd64};
			6'd14: e = '{6'h0f, 12'd68};
			6'd15: e = '{6'h13, 12'd72};
			6'd16: e = '{6'h14, 12'd80};
			6'd17: e = '{6'h15, 12'd88};
			6'd18: e = '{6'h19, 12'd96};
			6'd19: e = '{6'h16, 12'd104};
			6'd20: e = '{6'h1a, 12'd112};
			6'd21: e = '{6'h17, 12'd128};
			6'd22: e = '{6'h1c, 12'd144};
			6'd23: e = '{6'h1d, 12'd160};
			6'd24: e = '{6'h1e, 12'd192};
			6'd25: e = '{6'h22, 12'd224};
			6'd26: e = '{6'h1f, 12'd240};
			6'd27: e = '{6'h23, 12'd256};
			6'd28: e = '{6'h24, 12'd288};
			6'd29: e = '{6'h25, 12'd320};
			6'd30: e = '{6'h26, 12'd384};
			6'd31: e = '{6'h2a, 12'd448};
			6'd32: e = '{6'h27, 12'd480};
			6'd33: e = '{6'h2b, 12'd512};
			6'd34: e = '{6'h2c, 12'd576};
			6'd35: e = '{6'h2d, 12'd640};
			6'd36: e = '{6'h2e, 12'd768};
			6'd37: e = '{6'h32, 12'd896};
			6'd38: e = '{6'h2f, 12'd960};
			6'd39: e = '{6'h33, 12'd1024};
			6'd40: e = '{6'h34, 12'd1152};
			6'd41: e = '{6'h35, 12'd1280};
			6'd42: e = '{6'h36, 12'd1536};
			6'd43: e = '{6'h3a, 12'd1792};
			6'd44: e = '{6'h37, 12'd1920};
			6'd45: e = '{6'h3b, 12'd2048};
			6'd46: e = '{6'h3c, 12'd2304};
			6'd47: e = '{6'h3d, 12'd2560};
			6'd48: e = '{6'h3e, 12'd3072};
			6'd49: e = '{6'h3f, 12'd3840};
			default: e = '{6'h3f, 12'd3840};
		endcase
		return e;
	endfunction

endpackage

FILE: sv/icds_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icds_datapath
// Operand registers, radix-2 restoring divider, error compare and best-match
// registers, driven by commands from the controller.
// ----------------------------------------------------------------------------
module icds_datapath import icds_pkg::*; (
	input  logic         clk,
	input  logic [31:0]  source_clock_hz,
	input  logic [31:0]  wanted_rate_hz,
	input  icds_cmd_t    cmd,
	output icds_status_t st,
	output logic         accepted,
	output logic [5:0]   divider_code,
	output logic [1:0]   multiplier_code
);

	logic [31:0]      want_q;
	logic [31:0]      clk_q;
	logic [31:0]      quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [4:0]       cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [1:0]       shift_q;
	logic [31:0]      best_err_q;
	logic [5:0]       best_code_q;
	logic [1:0]       best_shift_q;
	logic             accepted_q;

	div_entry_t     entry;
	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;
	logic [31:0]    err;
	logic           better;
	logic [36:0]    want_x20;

	assign entry = div_table(idx_q);
	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	// rate > floor(clock / 20) is the same as 20 * rate > clock
	assign want_x20 = {5'b0, want_q} * {23'b0, MIN_DIVIDER};

	// quo_q holds the finished candidate rate when eval is issued
	assign err    = (want_q > quo_q) ? (want_q - quo_q) : (quo_q - want_q);
	assign better = err < best_err_q;

	assign st.div_last  = cnt_q == 5'd31;
	assign st.reject    = want_x20 > {5'b0, clk_q};
	assign st.exact     = better && (err == 32'd0);
	assign st.last_cand = (idx_q == LAST_IDX) && (shift_q == LAST_SHIFT);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			want_q       <= wanted_rate_hz;
			clk_q        <= source_clock_hz;
			idx_q        <= '0;
			shift_q      <= '0;
			best_err_q   <= '1;
			best_code_q  <= '0;
			best_shift_q <= '0;
			accepted_q   <= 1'b1;
		end
		if (cmd.step) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[30:0], ge};
			cnt_q <= cnt_q + 5'd1;
		end
		if (cmd.start) begin
			quo_q <= clk_q;
			rem_q <= '0;
			cnt_q <= '0;
			den_q <= {2'b00, entry.divider} << shift_q;
		end
		if (cmd.reject) begin
			accepted_q <= 1'b0;
		end
		if (cmd.eval && better) begin
			best_err_q   <= err;
			best_code_q  <= entry.code;
			best_shift_q <= shift_q;
		end
		if (cmd.next) begin
			if (idx_q == LAST_IDX) begin
				idx_q   <= '0;
				shift_q <= shift_q + 2'd1;
			end else begin
				idx_q <= idx_q + 6'd1;
			end
		end
	end

	assign accepted        = accepted_q;
	assign divider_code    = best_code_q;
	assign multiplier_code = best_shift_q;

endmodule

FILE: sv/icds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icds_ctrl
// Sequencer for the search: range check, candidate divisions, result word.
// ----------------------------------------------------------------------------
module icds_ctrl import icds_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  icds_status_t st,
	output icds_cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_CHECK    = 6'b000010,
		S_START    = 6'b000100,
		S_DIV_CAND = 6'b001000,
		S_EVAL     = 6'b010000,
		S_RESULT   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.reject) begin
					cmd.reject = 1'b1;
					state_d    = S_RESULT;
				end else begin
					cmd.start = 1'b1;
					state_d   = S_DIV_CAND;
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d   = S_DIV_CAND;
			end
			S_DIV_CAND: begin
				cmd.step = 1'b1;
				if (st.div_last) state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (st.exact || st.last_cand) begin
					state_d = S_RESULT;
				end else begin
					cmd.next = 1'b1;
					state_d  = S_START;
				end
			end
			S_RESULT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

FILE: sv/i2c_clock_divider_search.sv
`timescale 1ns / 1ps
// Flow: a rejected word (range check as 20 * rate against clock) goes straight
//   to the result; an accepted word runs each candidate through start, a 32-step
//   divide and compare on the shared 1-bit-per-cycle divider, over up to 150
//   candidates.
// Throughput: one word at a time; next input taken the cycle after the result is accepted.
// Reset: arst_n clears the sequencer to idle; data registers are not reset.
// ----------------------------------------------------------------------------
// i2c_clock_divider_search
// Picks the serial clock divider code and multiplier closest to a wanted rate.
// ----------------------------------------------------------------------------
module i2c_clock_divider_search import icds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] source_clock_hz,
	input  logic [31:0] wanted_rate_hz,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [5:0]  divider_code,
	output logic [1:0]  multiplier_code
);

	icds_cmd_t    cmd;
	icds_status_t st;

	icds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	icds_datapath u_datapath (
		.clk             (clk),
		.source_clock_hz (source_clock_hz),
		.wanted_rate_hz  (wanted_rate_hz),
		.cmd             (cmd),
		.st              (st),
		.accepted        (accepted),
		.divider_code    (divider_code),
		.multiplier_code (multiplier_code)
	);

endmodule
